### hdl/dash_pattern_row_rasterizer_top_macros.svh
// assertion macros for the dash pattern row rasterizer
`ifndef DASH_PATTERN_ROW_RASTERIZER_TOP_MACROS_SVH
`define DASH_PATTERN_ROW_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPRR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DPRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/dprr_pkg.sv
package dprr_pkg;

  // field widths
  localparam int SEG_W      = 8;
  localparam int PIX_W      = 9;
  localparam int VALUE_W    = 8;
  localparam int ROWLEN_W   = 9;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_W    = 4;

  // parameter defaults
  localparam int ROW_PIXELS_DEFAULT   = 512;
  localparam int MAX_SEGMENTS_DEFAULT = 8;

  // remainder pipeline: restoring steps per stage
  localparam int MOD_STEPS  = 3;
  localparam int MOD_STAGES = (PIX_W + MOD_STEPS - 1) / MOD_STEPS;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTHS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_COUNT   = 2'd1;

  // reset values and alpha codes
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;
  localparam logic [VALUE_W-1:0] ON_VALUE    = 8'd255;
  localparam logic [VALUE_W-1:0] OFF_VALUE   = 8'd0;

endpackage

### hdl/dprr_cfg.sv
module dprr_cfg #(
  parameter int ROW_PIXELS   = dprr_pkg::ROW_PIXELS_DEFAULT,
  parameter int MAX_SEGMENTS = dprr_pkg::MAX_SEGMENTS_DEFAULT,
  localparam int AW = $clog2(ROW_PIXELS),
  localparam int PW = dprr_pkg::SEG_W + $clog2(MAX_SEGMENTS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [dprr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dprr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               busy,
  output logic [PW-1:0]                      period,
  output logic [AW-1:0]                      used,
  output logic                               err,
  output logic [PW-1:0]                      ends [MAX_SEGMENTS]
);

  localparam int SW = $clog2(MAX_SEGMENTS);
  localparam int BW = $clog2(AW);
  localparam int AVAIL = ROW_PIXELS - 2;
  localparam logic [AW-1:0] AVAIL_V = AW'(AVAIL);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SUM  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [dprr_pkg::CFG_DATA_W-1:0] pattern_lengths;
  logic [dprr_pkg::COUNT_W-1:0]    segment_count;
  logic [1:0]                      phase;
  logic [SW-1:0]                   step;
  logic [BW-1:0]                   bitc;
  logic [PW-1:0]                   acc;
  logic [PW-1:0]                   acc_next;
  logic [PW-1:0]                   rem;
  logic [PW-1:0]                   rem_next;
  logic [PW:0]                     shifted;
  logic [dprr_pkg::COUNT_W-1:0]    nseg;
  logic [dprr_pkg::SEG_W-1:0]      len;

  assign busy = (phase != PH_IDLE);

  // segments in use, zero counts as one, large counts saturate
  always_comb begin
    if (segment_count == '0) begin
      nseg = dprr_pkg::COUNT_W'(1);
    end else if (32'(segment_count) > MAX_SEGMENTS) begin
      nseg = dprr_pkg::COUNT_W'(MAX_SEGMENTS);
    end else begin
      nseg = segment_count;
    end
  end

  // running sum of segment lengths, one segment a cycle
  assign len = pattern_lengths[step * dprr_pkg::SEG_W +: dprr_pkg::SEG_W];
  assign acc_next = (dprr_pkg::COUNT_W'(step) < nseg) ? acc + PW'(len) : acc;

  // one restoring division step of the usable width by the period
  assign shifted = {rem, AVAIL_V[bitc]};
  assign rem_next = (shifted >= {1'b0, period}) ? PW'(shifted - {1'b0, period}) : PW'(shifted);

  // register writes and recompute sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_lengths <= '0;
      segment_count   <= dprr_pkg::COUNT_RESET;
      phase           <= PH_SUM;
      step            <= '0;
      bitc            <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dprr_pkg::REG_PATTERN_LENGTHS: pattern_lengths <= cfg_data;
        dprr_pkg::REG_SEGMENT_COUNT:   segment_count <= cfg_data[dprr_pkg::COUNT_W-1:0];
        default: ;
      endcase
      phase <= PH_SUM;
      step  <= '0;
    end else begin
      unique case (phase)
        PH_SUM: begin
          if (step == SW'(MAX_SEGMENTS - 1)) begin
            phase <= PH_DIV;
            bitc  <= BW'(AW - 1);
          end else begin
            step <= step + 1'b1;
          end
        end
        PH_DIV: begin
          if (bitc == '0) begin
            phase <= PH_FIN;
          end else begin
            bitc <= bitc - 1'b1;
          end
        end
        PH_FIN:  phase <= PH_IDLE;
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // derived values: prefix sums, period, remainder, used length, error
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      acc <= '0;
    end else begin
      case (phase)
        PH_SUM: begin
          acc         <= acc_next;
          ends[step]  <= acc_next;
          if (step == SW'(MAX_SEGMENTS - 1)) begin
            period <= acc_next;
            rem    <= '0;
          end
        end
        PH_DIV: rem <= rem_next;
        PH_FIN: begin
          used <= AVAIL_V - AW'(rem);
          err  <= (period == '0) || (32'(period) >= AVAIL);
        end
        default: ;
      endcase
    end
  end

endmodule

### hdl/dprr_mod_stage.sv
module dprr_mod_stage #(
  parameter int PW    = dprr_pkg::SEG_W + 3,
  parameter int STEPS = dprr_pkg::MOD_STEPS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [PW-1:0]             period,
  input  logic                      up_valid,
  output logic                      up_stall,
  input  logic [dprr_pkg::PIX_W-1:0] up_num,
  input  logic [PW-1:0]             up_rem,
  input  logic                      up_zero,
  output logic                      dn_valid,
  input  logic                      dn_stall,
  output logic [dprr_pkg::PIX_W-1:0] dn_num,
  output logic [PW-1:0]             dn_rem,
  output logic                      dn_zero
);

  logic                       ready;
  logic [PW:0]                shifted;
  logic [PW-1:0]              rem_t;
  logic [dprr_pkg::PIX_W-1:0] num_t;

  assign ready    = !dn_valid || !dn_stall;
  assign up_stall = !ready;

  // restoring remainder steps, one dividend bit each
  always_comb begin
    rem_t   = up_rem;
    num_t   = up_num;
    shifted = '0;
    for (int k = 0; k < STEPS; k++) begin
      shifted = {rem_t, num_t[dprr_pkg::PIX_W-1]};
      num_t   = num_t << 1;
      if (shifted >= {1'b0, period}) begin
        rem_t = PW'(shifted - {1'b0, period});
      end else begin
        rem_t = PW'(shifted);
      end
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (ready) begin
      dn_valid <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      dn_num  <= num_t;
      dn_rem  <= rem_t;
      dn_zero <= up_zero;
    end
  end

endmodule

### hdl/dprr_out_stage.sv
module dprr_out_stage #(
  parameter int MAX_SEGMENTS = dprr_pkg::MAX_SEGMENTS_DEFAULT,
  parameter int PW = dprr_pkg::SEG_W + 3,
  parameter int AW = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [PW-1:0]                ends [MAX_SEGMENTS],
  input  logic [AW-1:0]                used,
  input  logic                         err,
  input  logic                         up_valid,
  output logic                         up_stall,
  input  logic [PW-1:0]                up_rem,
  input  logic                         up_zero,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dprr_pkg::VALUE_W-1:0] pixel_value,
  output logic [dprr_pkg::ROWLEN_W-1:0] row_length,
  output logic                         pattern_error
);

  logic                         ready;
  logic                         found;
  logic [dprr_pkg::VALUE_W-1:0] seg_value;

  assign ready    = !out_valid || !out_stall;
  assign up_stall = !ready;

  // first segment whose end lies past the pattern position
  always_comb begin
    found     = 1'b0;
    seg_value = dprr_pkg::OFF_VALUE;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (!found && (up_rem < ends[i])) begin
        found     = 1'b1;
        seg_value = (i % 2 == 0) ? dprr_pkg::ON_VALUE : dprr_pkg::OFF_VALUE;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= up_valid;
    end
  end

  // output payload, error pattern forces zeros, a past-copy index forces an off pixel
  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      pixel_value   <= (err || up_zero) ? dprr_pkg::OFF_VALUE : seg_value;
      row_length    <= err ? '0 : dprr_pkg::ROWLEN_W'(used);
      pattern_error <= err;
    end
  end

endmodule

### hdl/dash_pattern_row_rasterizer_top.sv
// Dash pattern row rasterizer: returns the alpha (255 on, 0 off) of one texel of a
// repeated dash pattern row per query, with the used row length and an error flag for
// a zero or oversize period. Queries are taken one per cycle while in_stall is low, and
// each result passes through an input stage that folds the index into a pattern
// position, three remainder stages of three restoring steps each, and the lookup and
// output register. After reset and after every register write the block recomputes
// its prefix sums and used length, holding in_stall high meanwhile.
module dash_pattern_row_rasterizer_top #(
  parameter int ROW_PIXELS   = dprr_pkg::ROW_PIXELS_DEFAULT,
  parameter int MAX_SEGMENTS = dprr_pkg::MAX_SEGMENTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dprr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dprr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dprr_pkg::PIX_W-1:0]    pixel_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dprr_pkg::VALUE_W-1:0]  pixel_value,
  output logic [dprr_pkg::ROWLEN_W-1:0] row_length,
  output logic                          pattern_error
);

`include "dash_pattern_row_rasterizer_top_macros.svh"

  localparam int AW = $clog2(ROW_PIXELS);
  localparam int PW = dprr_pkg::SEG_W + $clog2(MAX_SEGMENTS);
  localparam int NS = dprr_pkg::MOD_STAGES;

  logic                       cfg_busy;
  logic [PW-1:0]              period;
  logic [AW-1:0]              used;
  logic                       err;
  logic [PW-1:0]              ends [MAX_SEGMENTS];

  logic                       s_valid [NS+1];
  logic                       s_stall [NS+1];
  logic [dprr_pkg::PIX_W-1:0] s_num   [NS+1];
  logic [PW-1:0]              s_rem   [NS+1];
  logic                       s_zero  [NS+1];

  logic                       prep_ready;
  logic [dprr_pkg::PIX_W-1:0] pos;
  logic                       past_copy;

  // register file and derived values
  dprr_cfg #(
    .ROW_PIXELS  (ROW_PIXELS),
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .busy     (cfg_busy),
    .period   (period),
    .used     (used),
    .err      (err),
    .ends     (ends)
  );

  // fold the pixel index into a position inside the used length, or flag it past the copy
  always_comb begin
    pos       = '0;
    past_copy = 1'b0;
    if (pixel_index == '0) begin
      pos = '0;
    end else if (32'(pixel_index) <= 32'(used)) begin
      pos = pixel_index - 1'b1;
    end else if (32'(pixel_index) == 32'(used) + 1) begin
      pos = dprr_pkg::PIX_W'(used - 1'b1);
    end else begin
      past_copy = 1'b1;
    end
  end

  assign prep_ready = !s_valid[0] || !s_stall[0];
  assign in_stall   = cfg_busy || !prep_ready;

  // input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (prep_ready) begin
      s_valid[0] <= in_valid && !cfg_busy;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (prep_ready && in_valid && !cfg_busy) begin
      s_num[0]  <= pos;
      s_rem[0]  <= '0;
      s_zero[0] <= past_copy;
    end
  end

  // position modulo period over the remainder stages
  for (genvar g = 0; g < NS; g++) begin : g_mod
    dprr_mod_stage #(
      .PW   (PW),
      .STEPS(dprr_pkg::MOD_STEPS)
    ) u_mod (
      .clk     (clk),
      .rst     (rst),
      .period  (period),
      .up_valid(s_valid[g]),
      .up_stall(s_stall[g]),
      .up_num  (s_num[g]),
      .up_rem  (s_rem[g]),
      .up_zero (s_zero[g]),
      .dn_valid(s_valid[g+1]),
      .dn_stall(s_stall[g+1]),
      .dn_num  (s_num[g+1]),
      .dn_rem  (s_rem[g+1]),
      .dn_zero (s_zero[g+1])
    );
  end

  // segment lookup and output register
  dprr_out_stage #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .PW          (PW),
    .AW          (AW)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .ends         (ends),
    .used         (used),
    .err          (err),
    .up_valid     (s_valid[NS]),
    .up_stall     (s_stall[NS]),
    .up_rem       (s_rem[NS]),
    .up_zero      (s_zero[NS]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_value  (pixel_value),
    .row_length   (row_length),
    .pattern_error(pattern_error)
  );

  // checks
  `DPRR_ASSERT_IMPL(a_no_transfer_busy, in_valid && !in_stall, !cfg_busy, "transfer while recomputing")
  `DPRR_ASSERT_NEXT(a_write_recompute, cfg_write, cfg_busy, "write did not start recompute")
  `DPRR_ASSERT_IMPL(a_error_zeroes, out_valid && pattern_error, pixel_value == dprr_pkg::OFF_VALUE && row_length == '0, "error result not zero")
  `DPRR_ASSERT_IMPL(a_alpha_code, out_valid, pixel_value == dprr_pkg::ON_VALUE || pixel_value == dprr_pkg::OFF_VALUE, "bad alpha value")

endmodule
